[hw/rtl/cclf_pkg.sv]
// cclf_pkg: shared types and codes for the cnf clause literal filter
// holds the beat structs, result status codes, register indexes and sequencer states
// no dependencies
package cclf_pkg;

    // result status codes
    typedef enum logic [3:0] {
        STAT_ADDED      = 4'd0,
        STAT_DUPLICATE  = 4'd1,
        STAT_COMPLEMENT = 4'd2,
        STAT_RANGE_ERR  = 4'd3,
        STAT_KEPT       = 4'd4,
        STAT_TAUTOLOGY  = 4'd5,
        STAT_EMPTY      = 4'd6,
        STAT_EOF_ERR    = 4'd7,
        STAT_TOO_LONG   = 4'd8,
        STAT_HALTED     = 4'd9
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LIT,
        ST_CLOSE,
        ST_WALK
    } state_t;

    // configuration register indexes
    localparam logic CFG_VARIABLE_COUNT   = 1'b0;
    localparam logic CFG_EXPECTED_CLAUSES = 1'b1;

    // reset values of the configuration registers
    localparam logic [10:0] VARIABLE_COUNT_RST   = 11'd1024;
    localparam logic [15:0] EXPECTED_CLAUSES_RST = 16'd0;

    // input beat
    typedef struct packed {
        logic signed [11:0] literal;
        logic               end_of_input;
    } in_beat_t;

    // result beat
    typedef struct packed {
        status_t     status;
        logic [9:0]  variable;
        logic        negated;
        logic [16:0] clause_number;
        logic [7:0]  clause_length;
        logic [6:0]  longest_clause;
        logic [15:0] kept_clauses;
        logic        empty_clause_seen;
        logic        formula_complete;
        logic        fewer_clauses_found;
    } out_beat_t;

endpackage

[hw/rtl/cnf_clause_literal_filter.sv]
// cnf_clause_literal_filter: filters tokenized dimacs literals clause by clause
// one mark memory (two polarity bits per variable) and one member memory under a small sequencer
// depends on cclf_pkg
//
//   channel   ports                          direction  payload
//   input     s_valid s_ready s_data         in         cclf_pkg::in_beat_t
//   result    m_valid m_ready m_data         out        cclf_pkg::out_beat_t
//   config    cfg_we cfg_index cfg_wdata     in         16 bit write data
//
// a literal is accepted with its mark row read, then decided and its marks updated
// a clause end is accepted, then decided; then the member memory is walked to clear marks,
// or the whole mark memory is swept for a clause that reaches member capacity
// after reset the whole mark memory is swept before the first beat is taken
// the result register lets the next beat in while a result waits; a stalled result holds
// the sequencer only at the point where it writes the next result
module cnf_clause_literal_filter #(
    parameter int MAX_VARIABLES     = 1024,
    parameter int MAX_CLAUSE_LENGTH = 127,
    parameter int MAX_CLAUSES       = 65535
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cclf_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cclf_pkg::out_beat_t  m_data
);

    localparam int MEMBER_CAP = MAX_CLAUSE_LENGTH + 1;
    localparam int VAR_AW     = $clog2(MAX_VARIABLES);
    localparam int MEM_AW     = $clog2(MEMBER_CAP);
    localparam int LEN_W      = $clog2(MEMBER_CAP + 1);
    localparam int KEPT_W     = $clog2(MAX_CLAUSES + 1);
    localparam int LIM_W      = 18;
    localparam int CMP_W      = 25;

    localparam logic [VAR_AW-1:0] LAST_ROW  = VAR_AW'(MAX_VARIABLES - 1);
    localparam logic [LEN_W-1:0]  CAP_LEN   = LEN_W'(MEMBER_CAP);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_CLAUSE_LENGTH);
    localparam logic [KEPT_W-1:0] KEPT_MAX  = KEPT_W'(MAX_CLAUSES);
    localparam logic [LIM_W-1:0]  VAR_LIMIT = LIM_W'(MAX_VARIABLES);

    // memories: polarity marks per variable (bit 1 negative, bit 0 positive) and clause members
    logic [1:0]        mark_mem   [MAX_VARIABLES];
    logic [VAR_AW-1:0] member_mem [MEMBER_CAP];

    // control registers
    cclf_pkg::state_t  state_reg, state_next;
    logic [10:0]       varcnt_reg, varcnt_next;
    logic [15:0]       expected_reg, expected_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              taut_reg, taut_next;
    logic [16:0]       counter_reg, counter_next;
    logic [LEN_W-1:0]  longest_reg, longest_next;
    logic [KEPT_W-1:0] kept_reg, kept_next;
    logic              empty_reg, empty_next;
    logic              halted_reg, halted_next;
    logic [VAR_AW-1:0] sweep_reg, sweep_next;
    logic [LEN_W-1:0]  walk_idx_reg, walk_idx_next;
    logic [LEN_W-1:0]  walk_len_reg, walk_len_next;
    logic              walk_vld_reg, walk_vld_next;
    logic              m_valid_reg, m_valid_next;

    // payload registers
    logic [10:0]         var_reg, var_next;
    logic                neg_reg, neg_next;
    logic                eoi_reg, eoi_next;
    logic                end_reg, end_next;
    logic [1:0]          row_reg;
    logic [VAR_AW-1:0]   member_reg;
    cclf_pkg::out_beat_t out_reg, out_next;

    // memory write ports
    logic              mark_we;
    logic [VAR_AW-1:0] mark_waddr;
    logic [1:0]        mark_wdata;
    logic              mem_we;

    // input decode
    logic [11:0] in_raw;
    logic        in_neg;
    logic [10:0] in_var;
    logic        accept;
    logic        out_free;
    logic        out_load;
    logic        in_range;
    logic        complete_cur;
    logic        complete_new;

    assign in_raw   = s_data.literal;
    assign in_neg   = in_raw[11];
    assign in_var   = in_neg ? ~in_raw[10:0] : (in_raw[10:0] - 11'd1);
    assign s_ready  = (state_reg == cclf_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    assign in_range = (LIM_W'(var_reg) < LIM_W'(varcnt_reg)) && (LIM_W'(var_reg) < VAR_LIMIT);
    assign complete_cur = (counter_reg - 17'd1) >= {1'b0, expected_reg};
    assign complete_new = (counter_next - 17'd1) >= {1'b0, expected_reg};

    // sequencer: next state, counters, memory writes and result
    always_comb begin
        state_next    = state_reg;
        varcnt_next   = varcnt_reg;
        expected_next = expected_reg;
        length_next   = length_reg;
        taut_next     = taut_reg;
        counter_next  = counter_reg;
        longest_next  = longest_reg;
        kept_next     = kept_reg;
        empty_next    = empty_reg;
        halted_next   = halted_reg;
        sweep_next    = sweep_reg;
        walk_idx_next = walk_idx_reg;
        walk_len_next = walk_len_reg;
        walk_vld_next = walk_vld_reg;
        var_next      = var_reg;
        neg_next      = neg_reg;
        eoi_next      = eoi_reg;
        end_next      = end_reg;
        mark_we       = 1'b0;
        mark_waddr    = VAR_AW'(var_reg);
        mark_wdata    = 2'b00;
        mem_we        = 1'b0;
        out_load      = 1'b0;
        out_next      = out_reg;
        out_next.status        = cclf_pkg::STAT_HALTED;
        out_next.variable      = 10'd0;
        out_next.negated       = 1'b0;
        out_next.clause_length = 8'(length_reg);

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                cclf_pkg::CFG_VARIABLE_COUNT:   varcnt_next   = cfg_wdata[10:0];
                cclf_pkg::CFG_EXPECTED_CLAUSES: expected_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            // sweep the whole mark memory clear
            cclf_pkg::ST_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = sweep_reg;
                mark_wdata = 2'b00;
                if (sweep_reg == LAST_ROW) begin
                    state_next = cclf_pkg::ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // take a beat; the mark row read is issued alongside
            cclf_pkg::ST_IDLE: begin
                if (accept) begin
                    var_next = in_var;
                    neg_next = in_neg;
                    eoi_next = s_data.end_of_input;
                    end_next = s_data.end_of_input || (in_raw == 12'd0);
                    if (halted_reg || complete_cur || s_data.end_of_input
                            || (in_raw == 12'd0)) begin
                        state_next = cclf_pkg::ST_CLOSE;
                    end else begin
                        state_next = cclf_pkg::ST_LIT;
                    end
                end
            end

            // literal: range, complement and duplicate checks against the row
            cclf_pkg::ST_LIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = cclf_pkg::ST_IDLE;
                    if (!in_range) begin
                        out_next.status = cclf_pkg::STAT_RANGE_ERR;
                        halted_next     = 1'b1;
                    end else if (row_reg[!neg_reg]) begin
                        out_next.status = cclf_pkg::STAT_COMPLEMENT;
                        taut_next       = 1'b1;
                    end else if (row_reg[neg_reg]) begin
                        out_next.status = cclf_pkg::STAT_DUPLICATE;
                    end else begin
                        out_next.status = cclf_pkg::STAT_ADDED;
                        mark_we    = 1'b1;
                        mark_wdata = row_reg | (neg_reg ? 2'b10 : 2'b01);
                        if (length_reg < CAP_LEN) begin
                            mem_we      = 1'b1;
                            length_next = length_reg + 1'b1;
                        end
                    end
                    out_next.variable      = var_reg[9:0];
                    out_next.negated       = neg_reg;
                    out_next.clause_length = 8'(length_next);
                end
            end

            // clause end, or an item while halted or complete
            cclf_pkg::ST_CLOSE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = cclf_pkg::ST_IDLE;
                    if (halted_reg || complete_cur || !end_reg) begin
                        out_next.status = cclf_pkg::STAT_HALTED;
                    end else begin
                        if (length_reg == '0) begin
                            if (eoi_reg) begin
                                out_next.status = cclf_pkg::STAT_EOF_ERR;
                                halted_next     = 1'b1;
                            end else begin
                                out_next.status = cclf_pkg::STAT_EMPTY;
                                empty_next      = 1'b1;
                                counter_next    = counter_reg + 17'd1;
                            end
                        end else if (taut_reg) begin
                            out_next.status = cclf_pkg::STAT_TAUTOLOGY;
                            counter_next    = counter_reg + 17'd1;
                        end else if (length_reg > MAX_LEN) begin
                            out_next.status = cclf_pkg::STAT_TOO_LONG;
                            halted_next     = 1'b1;
                        end else begin
                            out_next.status = cclf_pkg::STAT_KEPT;
                            if (length_reg > longest_reg) begin
                                longest_next = length_reg;
                            end
                            if (kept_reg < KEPT_MAX) begin
                                kept_next = kept_reg + 1'b1;
                            end
                            counter_next = counter_reg + 17'd1;
                        end
                        // clear the clause's marks
                        length_next = '0;
                        taut_next   = 1'b0;
                        if (length_reg >= CAP_LEN) begin
                            sweep_next = '0;
                            state_next = cclf_pkg::ST_CLEAR;
                        end else if (length_reg != '0) begin
                            walk_idx_next = '0;
                            walk_len_next = length_reg;
                            walk_vld_next = 1'b0;
                            state_next    = cclf_pkg::ST_WALK;
                        end
                    end
                end
            end

            // walk the members: read one, clear its mark row the cycle after
            cclf_pkg::ST_WALK: begin
                if (walk_vld_reg) begin
                    mark_we    = 1'b1;
                    mark_waddr = member_reg;
                    mark_wdata = 2'b00;
                end
                if (walk_idx_reg != walk_len_reg) begin
                    walk_idx_next = walk_idx_reg + 1'b1;
                    walk_vld_next = 1'b1;
                end else begin
                    walk_vld_next = 1'b0;
                    state_next    = cclf_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = cclf_pkg::ST_IDLE;
            end
        endcase

        // summary fields after this beat
        out_next.clause_number       = counter_reg;
        out_next.longest_clause      = 7'(longest_next);
        out_next.kept_clauses        = 16'(kept_next);
        out_next.empty_clause_seen   = empty_next;
        out_next.formula_complete    = complete_new;
        out_next.fewer_clauses_found = complete_new
                                       && (CMP_W'(kept_next) < CMP_W'(expected_reg));

        // result register
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cclf_pkg::ST_CLEAR;
            varcnt_reg   <= cclf_pkg::VARIABLE_COUNT_RST;
            expected_reg <= cclf_pkg::EXPECTED_CLAUSES_RST;
            length_reg   <= '0;
            taut_reg     <= 1'b0;
            counter_reg  <= 17'd1;
            longest_reg  <= '0;
            kept_reg     <= '0;
            empty_reg    <= 1'b0;
            halted_reg   <= 1'b0;
            sweep_reg    <= '0;
            walk_idx_reg <= '0;
            walk_len_reg <= '0;
            walk_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            varcnt_reg   <= varcnt_next;
            expected_reg <= expected_next;
            length_reg   <= length_next;
            taut_reg     <= taut_next;
            counter_reg  <= counter_next;
            longest_reg  <= longest_next;
            kept_reg     <= kept_next;
            empty_reg    <= empty_next;
            halted_reg   <= halted_next;
            sweep_reg    <= sweep_next;
            walk_idx_reg <= walk_idx_next;
            walk_len_reg <= walk_len_next;
            walk_vld_reg <= walk_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // beat payload and result payload; the result holds until the next one is loaded
    always_ff @(posedge aclk) begin
        var_reg <= var_next;
        neg_reg <= neg_next;
        eoi_reg <= eoi_next;
        end_reg <= end_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // mark memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (accept) begin
            row_reg <= mark_mem[VAR_AW'(in_var)];
        end
    end

    // member memory: written on each added literal while it has room, read while walking
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            member_mem[length_reg[MEM_AW-1:0]] <= VAR_AW'(var_reg);
        end
        if (state_reg == cclf_pkg::ST_WALK) begin
            member_reg <= member_mem[walk_idx_reg[MEM_AW-1:0]];
        end
    end

endmodule
